>>> sv/vector_to_yaw_pitch_core_defines.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef VECTOR_TO_YAW_PITCH_CORE_DEFINES_SVH
`define VECTOR_TO_YAW_PITCH_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define VYP_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("vyp check failed");
// Next-cycle implication checked outside reset.
`define VYP_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("vyp check failed");
`endif

>>> sv/vyp_pkg.sv
// Package for the vector-to-yaw/pitch core: word types, widths, arctangent table.
// Depends on nothing.
package vyp_pkg;
  localparam int CoordWidth = 16;
  localparam int AngleFracBits = 6;
  localparam int CordicStages = 16;
  localparam int GuardBits = 16;
  localparam int DatW = 40;
  localparam int OutW = 15;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic [31:0] GainQ30 = 32'd1768195363;
  localparam int Latency = 2 * CordicStages + 4;

  typedef struct packed {
    logic signed [CoordWidth-1:0] vec_x;
    logic signed [CoordWidth-1:0] vec_y;
    logic signed [CoordWidth-1:0] vec_z;
  } in_word_t;

  typedef struct packed {
    logic [OutW-1:0] yaw_deg;
    logic [OutW-1:0] pitch_deg;
  } out_word_t;

  typedef struct packed {
    logic signed [DatW-1:0] x;
    logic signed [DatW-1:0] y;
    logic [31:0] ang;
  } rot_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  // Binary angle to 1/64 degree, round half up, wrap a full turn to zero.
  function automatic logic [OutW-1:0] to_units(input logic [31:0] a);
    logic [63:0] p;
    logic [31:0] v;
    p = {32'd0, a} * 64'(360 << AngleFracBits) + 64'h8000_0000;
    v = p[63:32];
    if (v >= 32'(360 << AngleFracBits)) v = 32'd0;
    return v[OutW-1:0];
  endfunction
endpackage

>>> sv/vector_to_yaw_pitch_core.sv
// Top level of the vector-to-yaw/pitch core.
// Depends on vyp_pkg and vyp_cordic.
//
// Takes one vector word per cycle (busy is always low) and returns yaw and pitch
// in 1/64 degree through the two chained 16-stage CORDIC pipelines plus prep,
// gain multiply, pitch-load and convert stages. done strobes for one cycle with
// the result word; the receiver cannot stall, so no backpressure exists anywhere
// in the pipe.
module vector_to_yaw_pitch_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  vyp_pkg::in_word_t    in_word,
  output logic                 done,
  output vyp_pkg::out_word_t   out_word
);
  localparam int W = vyp_pkg::DatW;

  assign busy = 1'b0;

  // Stage 1: fold the left half-plane, scale by guard bits, flag zero xy.
  logic v1;
  vyp_pkg::rot_t r1;
  logic [47:0] s1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    s1 <= in_word;
    if (in_word.vec_x < 0) begin
      r1.x <= -(W'(in_word.vec_x) <<< vyp_pkg::GuardBits);
      r1.y <= -(W'(in_word.vec_y) <<< vyp_pkg::GuardBits);
      r1.ang <= vyp_pkg::HalfTurn;
    end else begin
      r1.x <= W'(in_word.vec_x) <<< vyp_pkg::GuardBits;
      r1.y <= W'(in_word.vec_y) <<< vyp_pkg::GuardBits;
      r1.ang <= 32'd0;
    end
  end

  // Yaw CORDIC.
  logic v2;
  vyp_pkg::rot_t r2;
  logic [47:0] s2;
  vyp_cordic u_yaw (.clk, .rst, .in_valid(v1), .in_rot(r1), .in_side(s1),
    .out_valid(v2), .out_rot(r2), .out_side(s2));

  // Stage: scale z by the CORDIC gain so both pitch legs carry it.
  logic v3;
  logic signed [W-1:0] mag3;
  logic [31:0] yaw3;
  logic signed [W+8-1:0] zg3;
  logic [47:0] s3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    mag3 <= r2.x;
    yaw3 <= r2.ang;
    s3 <= s2;
    zg3 <= (W+8)'(signed'(s2[15:0]) * signed'({1'b0, vyp_pkg::GainQ30}));
  end

  logic v4;
  vyp_pkg::rot_t r4;
  logic [47:0] s4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    r4.x <= mag3;
    r4.y <= W'(zg3 >>> (30 - vyp_pkg::GuardBits));
    r4.ang <= 32'd0;
    s4 <= {yaw3, s3[15:0]};
  end

  // Pitch CORDIC; side band carries the yaw angle and z.
  logic v5;
  vyp_pkg::rot_t r5;
  logic [47:0] s5;
  vyp_cordic u_pitch (.clk, .rst, .in_valid(v4), .in_rot(r4), .in_side(s4),
    .out_valid(v5), .out_rot(r5), .out_side(s5));

  // Zero-xy flag travels alongside via a shift line of the flag taken from the input word.
  localparam int ZD = 2 * vyp_pkg::CordicStages + 3;
  logic [ZD-1:0] zl;
  always_ff @(posedge clk) begin
    zl <= {zl[ZD-2:0], (in_word.vec_x == 16'sd0) && (in_word.vec_y == 16'sd0)};
  end

  // Final stage: convert to degree units and apply the zero-xy case.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v5;
    if (zl[ZD-1]) begin
      out_word.yaw_deg <= '0;
      out_word.pitch_deg <= (signed'(s5[15:0]) > 0) ?
        vyp_pkg::OutW'(90 << vyp_pkg::AngleFracBits) :
        vyp_pkg::OutW'(270 << vyp_pkg::AngleFracBits);
    end else begin
      out_word.yaw_deg <= vyp_pkg::to_units(s5[47:16]);
      out_word.pitch_deg <= vyp_pkg::to_units(r5.ang);
    end
  end
endmodule

>>> sv/vyp_cordic.sv
// Unrolled vectoring CORDIC, one registered stage per iteration.
// Depends on vyp_pkg.
module vyp_cordic (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  vyp_pkg::rot_t in_rot,
  input  logic [47:0]  in_side,
  output logic         out_valid,
  output vyp_pkg::rot_t out_rot,
  output logic [47:0]  out_side
);
  localparam int N = vyp_pkg::CordicStages;
  vyp_pkg::rot_t st [1:N];
  logic [47:0] sd [1:N];
  logic [N:1] vl;

  // One micro-rotation: drive y toward zero, accumulate the angle.
  function automatic vyp_pkg::rot_t cordic_step(input vyp_pkg::rot_t r, input int i);
    vyp_pkg::rot_t nx;
    logic signed [vyp_pkg::DatW-1:0] dx, dy;
    dx = r.y >>> i;
    dy = r.x >>> i;
    if (!r.y[vyp_pkg::DatW-1]) begin
      nx.x = r.x + dx;
      nx.y = r.y - dy;
      nx.ang = r.ang + vyp_pkg::atan_entry(i);
    end else begin
      nx.x = r.x - dx;
      nx.y = r.y + dy;
      nx.ang = r.ang - vyp_pkg::atan_entry(i);
    end
    return nx;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vl <= '0;
    else vl <= {vl[N-1:1], in_valid};
    st[1] <= cordic_step(in_rot, 0);
    sd[1] <= in_side;
    for (int i = 1; i < N; i++) begin
      st[i+1] <= cordic_step(st[i], i);
      sd[i+1] <= sd[i];
    end
  end

  assign out_valid = vl[N];
  assign out_rot = st[N];
  assign out_side = sd[N];
endmodule

>>> sv/vyp_checker.sv
// Port-level checker for the vector-to-yaw/pitch core, bound to the top level.
// Depends on vyp_pkg and the defines header.
`include "vector_to_yaw_pitch_core_defines.svh"
module vyp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input vyp_pkg::out_word_t out_word
);
  `VYP_ASSERT_IMP(a_never_busy, 1'b1, !busy)
  `VYP_ASSERT_IMP(a_done_latency, done, $past(start, vyp_pkg::Latency))
  `VYP_ASSERT_IMP(a_range, done, (out_word.yaw_deg < 15'd23040) && (out_word.pitch_deg < 15'd23040))
endmodule

bind vector_to_yaw_pitch_core vyp_checker u_chk (.clk, .rst, .start, .busy, .done, .out_word);

>>> dv/tb.sv
// Testbench for vector_to_yaw_pitch_core: drives vector words, predicts yaw and
// pitch with a bit-true CORDIC model and checks each result word in order.
// Depends on vyp_pkg and the core RTL.
`timescale 1ns / 100ps

class angle_scoreboard;
  vyp_pkg::out_word_t pending_angles[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Vectoring CORDIC: drive y to zero, accumulate the binary angle.
  static function logic [31:0] rotate_to_axis(ref longint mag, input longint yv,
                                              input logic [31:0] base);
    longint dx;
    longint dy;
    logic [31:0] ang;
    ang = base;
    for (int i = 0; i < vyp_pkg::CordicStages; i++) begin
      dx = yv >>> i;
      dy = mag >>> i;
      if (yv >= 0) begin
        mag += dx;
        yv -= dy;
        ang += step_angle(i);
      end else begin
        mag -= dx;
        yv += dy;
        ang -= step_angle(i);
      end
    end
    return ang;
  endfunction

  static function logic [31:0] step_angle(input int i);
    logic [31:0] tab [0:15];
    tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
    return tab[i];
  endfunction

  // Binary angle to 1/64 degree, ties up, full turn wraps to zero.
  static function logic [14:0] binary_to_degrees(input logic [31:0] a);
    logic [63:0] v;
    v = ({32'd0, a} * 64'd23040 + 64'h8000_0000) >> 32;
    if (v >= 64'd23040) v = 0;
    return v[14:0];
  endfunction

  function void note_vector(input vyp_pkg::in_word_t w);
    vyp_pkg::out_word_t e;
    longint x;
    longint y;
    longint z;
    longint zs;
    logic [31:0] base;
    x = w.vec_x;
    y = w.vec_y;
    z = w.vec_z;
    if (x == 0 && y == 0) begin
      e.yaw_deg = '0;
      e.pitch_deg = (z > 0) ? 15'd5760 : 15'd17280;
    end else begin
      x = x * 65536;
      y = y * 65536;
      base = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        base = vyp_pkg::HalfTurn;
      end
      e.yaw_deg = binary_to_degrees(rotate_to_axis(x, y, base));
      zs = (z * 64'sd1768195363) >>> 14;
      e.pitch_deg = binary_to_degrees(rotate_to_axis(x, zs, 32'd0));
    end
    pending_angles.push_back(e);
  endfunction

  function void check_angles(input vyp_pkg::out_word_t got);
    vyp_pkg::out_word_t e;
    if (pending_angles.size() == 0) begin
      $display("%0t: unexpected result word yaw=%0d pitch=%0d", $time,
               got.yaw_deg, got.pitch_deg);
      errors++;
      return;
    end
    e = pending_angles.pop_front();
    if (got.yaw_deg !== e.yaw_deg) begin
      $display("%0t: yaw mismatch expected %0d actual %0d", $time, e.yaw_deg,
               got.yaw_deg);
      errors++;
    end
    if (got.pitch_deg !== e.pitch_deg) begin
      $display("%0t: pitch mismatch expected %0d actual %0d", $time, e.pitch_deg,
               got.pitch_deg);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int WatchdogLimit = 2000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  vyp_pkg::in_word_t in_word;
  vyp_pkg::out_word_t out_word;

  angle_scoreboard sb;
  int idle_cycles;

  vector_to_yaw_pitch_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .done(done),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every strobed result word; count cycles with no word moving.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_angles(out_word);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Stop the run if the idle count reaches WatchdogLimit with no word moving.
  always @(posedge clk) begin
    if (!rst && idle_cycles >= WatchdogLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, and stretches of back-to-back words.
  // Drop start only when a real gap follows.
  task automatic idle_gap(input bit burst);
    int n;
    if (burst) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Present one vector word and hold it until accepted.
  task automatic send_vector(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input bit burst);
    vyp_pkg::in_word_t w;
    w.vec_x = x;
    w.vec_y = y;
    w.vec_z = z;
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sb.note_vector(w);
    idle_gap(burst);
  endtask

  // Random coordinate: extremes, small values, zero or full range.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] ext [0:4];
    bit burst;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    in_word = '0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero horizontal part with each sign of z, axes and extremes.
    send_vector(16'h0000, 16'h0000, 16'h0001, 0);
    send_vector(16'h0000, 16'h0000, 16'h0000, 0);
    send_vector(16'h0000, 16'h0000, 16'hFFFF, 0);
    send_vector(16'h0000, 16'h0000, 16'h8000, 0);
    send_vector(16'h0001, 16'hFFFF, 16'h0000, 0);
    send_vector(16'h0001, 16'h0000, 16'h0000, 0);
    send_vector(16'hFFFF, 16'h0000, 16'h0000, 0);
    send_vector(16'h0000, 16'h0001, 16'h0000, 0);
    send_vector(16'h0000, 16'hFFFF, 16'h0000, 0);
    send_vector(16'h7FFF, 16'hFFFF, 16'hFFFF, 0);
    send_vector(16'h7FFF, 16'h0000, 16'h0000, 0);
    ext = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
    for (int i = 0; i < 5; i += 2)
      for (int j = 0; j < 5; j += 2)
        send_vector(ext[i], ext[j], ext[(i + j) % 5], 0);

    // Random vectors with bursts of back-to-back words.
    burst = 0;
    for (int n = 0; n < 1700; n++) begin
      if ($urandom_range(0, 19) == 0) burst = ~burst;
      send_vector(pick_coord(), pick_coord(), pick_coord(), burst);
    end
    start <= 1'b0;

    while (sb.pending_angles.size() != 0) @(posedge clk);
    repeat (vyp_pkg::Latency + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
